// File: hw/rtl/utf8d_pkg.sv
// Shared types, constants and lead byte classification for the UTF-8 stream decoder.
`default_nettype none

package utf8d_pkg;

	localparam logic [20:0] REPL_CP   = 21'h00FFFD;
	localparam logic [20:0] MAX_CP    = 21'h10FFFF;
	localparam logic [20:0] SURR_LO   = 21'h00D800;
	localparam logic [20:0] SURR_HI   = 21'h00DFFF;
	localparam logic [20:0] MIN_CP2   = 21'h000080;
	localparam logic [20:0] MIN_CP3   = 21'h000800;
	localparam logic [20:0] MIN_CP4   = 21'h010000;
	localparam logic [1:0]  CONT_TAG  = 2'b10;

	// sequence lengths; LEN_BAD marks a byte that cannot start a sequence
	localparam logic [2:0] LEN_BAD = 3'd0;
	localparam logic [2:0] LEN_1   = 3'd1;
	localparam logic [2:0] LEN_2   = 3'd2;
	localparam logic [2:0] LEN_3   = 3'd3;
	localparam logic [2:0] LEN_4   = 3'd4;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       string_end;
	} byte_item_t;

	typedef struct packed {
		logic [20:0] code_point;
		logic        replaced;
		logic        run_last;
		logic        string_done;
	} cp_item_t;

	// outcome of one decode step at the current buffer position
	typedef struct packed {
		logic        emit;
		logic [20:0] cp;
		logic        repl;
		logic [2:0]  adv;
	} step_t;

	function automatic logic [2:0] lead_len(input logic [7:0] lead);
		logic [2:0] len;
		begin
			case (lead) inside
				[8'h00:8'h7F]: len = LEN_1;
				[8'hC0:8'hDF]: len = LEN_2;
				[8'hE0:8'hEF]: len = LEN_3;
				[8'hF0:8'hF7]: len = LEN_4;
				default:       len = LEN_BAD;
			endcase
			return len;
		end
	endfunction

endpackage

`default_nettype wire

// File: hw/rtl/utf8d_step_unit.sv
// Decodes one sequence at the head of a four byte window and reports how far to advance.
`default_nettype none

module utf8d_step_unit
	import utf8d_pkg::*;
(
	input  wire logic [31:0] win,
	input  wire logic [2:0]  avail,
	input  wire logic        fin,
	output step_t            step
);

	logic [7:0]  lead;
	logic [2:0]  len;
	logic        cont_ok;
	logic [20:0] cp;
	logic        overlong;

	assign lead = win[7:0];
	assign len  = lead_len(lead);

	always_comb begin
		cont_ok  = 1'b1;
		cp       = {13'd0, lead};
		overlong = 1'b0;
		case (len)
			LEN_2: begin
				cont_ok  = (win[15:14] == CONT_TAG);
				cp       = {10'd0, lead[4:0], win[13:8]};
				overlong = (cp < MIN_CP2);
			end
			LEN_3: begin
				cont_ok  = (win[15:14] == CONT_TAG) && (win[23:22] == CONT_TAG);
				cp       = {5'd0, lead[3:0], win[13:8], win[21:16]};
				overlong = (cp < MIN_CP3);
			end
			LEN_4: begin
				cont_ok  = (win[15:14] == CONT_TAG) && (win[23:22] == CONT_TAG)
					&& (win[31:30] == CONT_TAG);
				cp       = {lead[2:0], win[13:8], win[21:16], win[29:24]};
				overlong = (cp < MIN_CP4);
			end
			default: begin
				cont_ok  = 1'b1;
				cp       = {13'd0, lead};
				overlong = 1'b0;
			end
		endcase
	end

	always_comb begin
		step.emit = 1'b1;
		step.cp   = REPL_CP;
		step.repl = 1'b1;
		step.adv  = 3'd1;
		if (len == LEN_BAD) begin
			step.adv = 3'd1;
		end else if (avail < len) begin
			// truncated: one replacement at string end, otherwise hold and wait
			step.emit = fin;
			step.adv  = fin ? avail : 3'd0;
		end else if (cont_ok && !overlong && (cp <= MAX_CP)
				&& !((cp >= SURR_LO) && (cp <= SURR_HI))) begin
			step.cp   = cp;
			step.repl = 1'b0;
			step.adv  = len;
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/utf8_stream_decoder.sv
// A byte is taken while idle, then each result is registered into the output register.
// No new byte is taken until the run ends; the step unit decodes one sequence of the held window
// per cycle while the output register is free.
// Output stalls hold the step unit until the output register frees.
// Reset (arst_n low) clears the held count, sequencer and output valid; held bytes are not cleared.
`default_nettype none

module utf8_stream_decoder
	import utf8d_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       byte_valid,
	output logic            byte_stall,
	input  wire byte_item_t byte_data,
	output logic            cp_valid,
	input  wire logic       cp_stall,
	output cp_item_t        cp_data
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_RUN  = 2'b10
	} state_t;

	state_t      state_q;
	logic [31:0] buf_q;
	logic [2:0]  cnt_q;
	logic [1:0]  pos_q;
	logic        end_q;
	logic        out_valid_q;
	cp_item_t    out_q;

	logic [31:0] win;
	logic [2:0]  avail;
	step_t       step;
	logic [2:0]  np;
	logic [31:0] nwin;
	logic [2:0]  nlen;
	logic [2:0]  rem;
	logic        last;
	logic        go;
	logic        accept;
	logic        load_out;
	logic        finish;

	assign accept   = byte_valid && !byte_stall;
	assign byte_stall = (state_q != ST_IDLE);

	assign win   = buf_q >> {pos_q, 3'b000};
	assign avail = cnt_q - {1'b0, pos_q};

	utf8d_step_unit u_step (
		.win  (win),
		.avail(avail),
		.fin  (end_q),
		.step (step)
	);

	assign np   = {1'b0, pos_q} + step.adv;
	assign nwin = buf_q >> {np, 3'b000};
	assign nlen = lead_len(nwin[7:0]);
	assign rem  = cnt_q - np;
	// last result when nothing remains or the remaining bytes must wait for more input
	assign last = (np == cnt_q) || (!end_q && (nlen != LEN_BAD) && (rem < nlen));

	assign go       = !out_valid_q || !cp_stall;
	assign load_out = (state_q == ST_RUN) && step.emit && go;
	assign finish   = (state_q == ST_RUN) && (!step.emit || (go && last));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= 3'd0;
			pos_q       <= 2'd0;
			end_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						cnt_q   <= cnt_q + 3'd1;
						pos_q   <= 2'd0;
						end_q   <= byte_data.string_end;
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (finish) begin
						cnt_q   <= rem;
						pos_q   <= 2'd0;
						state_q <= ST_IDLE;
					end else if (load_out) begin
						pos_q <= np[1:0];
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!cp_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			buf_q[{cnt_q[1:0], 3'b000} +: 8] <= byte_data.in_byte;
		end else if (finish) begin
			buf_q <= nwin;
		end
		if (load_out) begin
			out_q.code_point  <= step.cp;
			out_q.replaced    <= step.repl;
			out_q.run_last    <= last;
			out_q.string_done <= last && end_q;
		end
	end

	assign cp_valid = out_valid_q;
	assign cp_data  = out_q;

	a_idle_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> cnt_q <= 3'd3)
		else $error("held byte count above three while idle");

	a_run_pos: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RUN |-> {1'b0, pos_q} < cnt_q)
		else $error("decode position past held bytes");

	a_accept_run: assert property (@(posedge clk) disable iff (!arst_n)
		byte_valid && !byte_stall |=> state_q == ST_RUN)
		else $error("sequencer did not start after byte transfer");

	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		cp_valid |-> !cp_data.string_done || cp_data.run_last)
		else $error("string_done without run_last");

	a_repl_cp: assert property (@(posedge clk) disable iff (!arst_n)
		cp_valid && cp_data.replaced |-> cp_data.code_point == REPL_CP)
		else $error("replacement flag on a decoded code point");

	a_end_flush: assert property (@(posedge clk) disable iff (!arst_n)
		finish && end_q |=> cnt_q == 3'd0)
		else $error("bytes held across string end");

endmodule

`default_nettype wire
